>>> hdl/snc_pkg.sv
// ----------------------------------------------------------------------------
// snc_pkg: shared types and constants for the spi nand command sequencer
// Holds the item structs, result kinds and the script record passed from the
// front part to the back part.
// ----------------------------------------------------------------------------
package snc_pkg;

  localparam int unsigned DeviceCountDefault = 8;

  // operation codes
  localparam logic [2:0] OP_ERASE   = 3'd0;
  localparam logic [2:0] OP_PROGRAM = 3'd1;
  localparam logic [2:0] OP_ERPROG  = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_ID      = 3'd4;
  localparam logic [2:0] OP_UNPROT  = 3'd5;
  localparam logic [2:0] OP_PAYLOAD = 3'd6;
  localparam logic [2:0] OP_RXBYTE  = 3'd7;

  // result kinds
  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_RD   = 2'd1;
  localparam logic [1:0] KIND_ID   = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [2:0]  device;
    logic [15:0] page_address;
    logic [11:0] column_address;
    logic [11:0] length;
    logic [7:0]  data_byte;
  } snc_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] value;
    logic        frame_end;
    logic [7:0]  device_select;
    logic        last;
  } snc_out_t;

  // one result slot of a script
  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] value;
    logic        frame_end;
  } snc_slot_t;

  // everything one item causes: up to eight results, same device select
  typedef struct packed {
    snc_slot_t [7:0] slots;
    logic [3:0]      count;
    logic [7:0]      sel;
  } snc_script_t;

endpackage

>>> hdl/snc_front.sv
// ----------------------------------------------------------------------------
// snc_front: operation decoder and phase tracker
// Accepts one item per cycle, updates the operation state and writes the
// complete result script of the item into the script queue.
// ----------------------------------------------------------------------------
module snc_front #(
  parameter int unsigned DeviceCount = snc_pkg::DeviceCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 valid_i,
  input  snc_pkg::snc_in_t     item_i,
  output logic                 script_valid_o,
  output snc_pkg::snc_script_t script_o
);
  import snc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE, PH_POLL_DONE, PH_POLL_ERASE, PH_POLL_READ, PH_PAYLOAD, PH_READ_DATA,
    PH_ID_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [2:0]  dev_q, dev_d;
  logic [15:0] page_q, page_d;
  logic [11:0] col_q, col_d;
  logic [11:0] rem_q, rem_d;
  logic [23:0] id_q, id_d;
  logic [7:0]  prot_q;
  snc_script_t scr;
  logic [11:0] rem_dec;
  logic [23:0] id_next;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prot_q <= 8'h83;
    end else if (cfg_we_i) begin
      prot_q <= cfg_wdata_i;
    end
  end

  // script build and phase update
  always_comb begin
    phase_d = phase_q;
    dev_d   = dev_q;
    page_d  = page_q;
    col_d   = col_q;
    rem_d   = rem_q;
    id_d    = id_q;
    scr     = '0;
    rem_dec = rem_q - 12'd1;
    id_next = {id_q[15:0], item_i.data_byte};
    if (valid_i) begin
      if (item_i.operation <= OP_UNPROT) begin
        if (phase_q == PH_IDLE && 32'(item_i.device) < DeviceCount) begin
          dev_d  = item_i.device;
          page_d = item_i.page_address;
          col_d  = item_i.column_address;
          rem_d  = (item_i.operation >= OP_PROGRAM && item_i.operation <= OP_READ)
                   ? item_i.length : 12'd0;
          unique case (item_i.operation)
            OP_ERASE, OP_ERPROG: begin
              scr.slots[0] = '{KIND_TX, 24'h06, 1'b1};
              scr.slots[1] = '{KIND_TX, 24'hD8, 1'b0};
              scr.slots[2] = '{KIND_TX, 24'hC3, 1'b0};
              scr.slots[3] = '{KIND_TX, {16'd0, item_i.page_address[15:8]}, 1'b0};
              scr.slots[4] = '{KIND_TX, {16'd0, item_i.page_address[7:0]}, 1'b1};
              scr.slots[5] = '{KIND_TX, 24'h0F, 1'b0};
              scr.slots[6] = '{KIND_TX, 24'hC3, 1'b0};
              scr.slots[7] = '{KIND_TX, 24'h00, 1'b1};
              scr.count = 4'd8;
              phase_d = (item_i.operation == OP_ERASE) ? PH_POLL_DONE : PH_POLL_ERASE;
            end
            OP_PROGRAM: begin
              scr.slots[0] = '{KIND_TX, 24'h06, 1'b1};
              if (item_i.length == 12'd0) begin
                scr.slots[1] = '{KIND_TX, 24'h10, 1'b0};
                scr.slots[2] = '{KIND_TX, 24'h00, 1'b0};
                scr.slots[3] = '{KIND_TX, {16'd0, item_i.page_address[15:8]}, 1'b0};
                scr.slots[4] = '{KIND_TX, {16'd0, item_i.page_address[7:0]}, 1'b1};
                scr.slots[5] = '{KIND_TX, 24'h0F, 1'b0};
                scr.slots[6] = '{KIND_TX, 24'hC3, 1'b0};
                scr.slots[7] = '{KIND_TX, 24'h00, 1'b1};
                scr.count = 4'd8;
                phase_d = PH_POLL_DONE;
              end else begin
                scr.slots[1] = '{KIND_TX, 24'h02, 1'b0};
                scr.slots[2] = '{KIND_TX, {20'd0, item_i.column_address[11:8]}, 1'b0};
                scr.slots[3] = '{KIND_TX, {16'd0, item_i.column_address[7:0]}, 1'b0};
                scr.count = 4'd4;
                phase_d = PH_PAYLOAD;
              end
            end
            OP_READ: begin
              scr.slots[0] = '{KIND_TX, 24'h13, 1'b0};
              scr.slots[1] = '{KIND_TX, 24'h00, 1'b0};
              scr.slots[2] = '{KIND_TX, {16'd0, item_i.page_address[15:8]}, 1'b0};
              scr.slots[3] = '{KIND_TX, {16'd0, item_i.page_address[7:0]}, 1'b1};
              scr.slots[4] = '{KIND_TX, 24'h0F, 1'b0};
              scr.slots[5] = '{KIND_TX, 24'hC3, 1'b0};
              scr.slots[6] = '{KIND_TX, 24'h00, 1'b1};
              scr.count = 4'd7;
              phase_d = PH_POLL_READ;
            end
            OP_ID: begin
              scr.slots[0] = '{KIND_TX, 24'h9F, 1'b0};
              scr.slots[1] = '{KIND_TX, 24'h00, 1'b0};
              scr.slots[2] = '{KIND_TX, 24'h00, 1'b0};
              scr.slots[3] = '{KIND_TX, 24'h00, 1'b0};
              scr.slots[4] = '{KIND_TX, 24'h00, 1'b1};
              scr.count = 4'd5;
              rem_d = 12'd3;
              id_d = '0;
              phase_d = PH_ID_DATA;
            end
            default: begin
              scr.slots[0] = '{KIND_TX, 24'h1F, 1'b0};
              scr.slots[1] = '{KIND_TX, 24'hA0, 1'b0};
              scr.slots[2] = '{KIND_TX, {16'd0, prot_q}, 1'b1};
              scr.slots[3] = '{KIND_DONE, 24'h0, 1'b0};
              scr.count = 4'd4;
              phase_d = PH_IDLE;
            end
          endcase
        end
      end else if (item_i.operation == OP_PAYLOAD) begin
        if (phase_q == PH_PAYLOAD && rem_q != 12'd0) begin
          rem_d = rem_dec;
          if (rem_dec != 12'd0) begin
            scr.slots[0] = '{KIND_TX, {16'd0, item_i.data_byte}, 1'b0};
            scr.count = 4'd1;
          end else begin
            scr.slots[0] = '{KIND_TX, {16'd0, item_i.data_byte}, 1'b1};
            scr.slots[1] = '{KIND_TX, 24'h10, 1'b0};
            scr.slots[2] = '{KIND_TX, 24'h00, 1'b0};
            scr.slots[3] = '{KIND_TX, {16'd0, page_q[15:8]}, 1'b0};
            scr.slots[4] = '{KIND_TX, {16'd0, page_q[7:0]}, 1'b1};
            scr.slots[5] = '{KIND_TX, 24'h0F, 1'b0};
            scr.slots[6] = '{KIND_TX, 24'hC3, 1'b0};
            scr.slots[7] = '{KIND_TX, 24'h00, 1'b1};
            scr.count = 4'd8;
            phase_d = PH_POLL_DONE;
          end
        end
      end else if (phase_q == PH_POLL_DONE || phase_q == PH_POLL_ERASE ||
                   phase_q == PH_POLL_READ) begin
        if (item_i.data_byte[0]) begin
          scr.slots[0] = '{KIND_TX, 24'h0F, 1'b0};
          scr.slots[1] = '{KIND_TX, 24'hC3, 1'b0};
          scr.slots[2] = '{KIND_TX, 24'h00, 1'b1};
          scr.count = 4'd3;
        end else if (phase_q == PH_POLL_DONE) begin
          scr.slots[0] = '{KIND_DONE, 24'h0, 1'b0};
          scr.count = 4'd1;
          phase_d = PH_IDLE;
        end else if (phase_q == PH_POLL_ERASE) begin
          scr.slots[0] = '{KIND_TX, 24'h06, 1'b1};
          if (rem_q == 12'd0) begin
            scr.slots[1] = '{KIND_TX, 24'h10, 1'b0};
            scr.slots[2] = '{KIND_TX, 24'h00, 1'b0};
            scr.slots[3] = '{KIND_TX, {16'd0, page_q[15:8]}, 1'b0};
            scr.slots[4] = '{KIND_TX, {16'd0, page_q[7:0]}, 1'b1};
            scr.slots[5] = '{KIND_TX, 24'h0F, 1'b0};
            scr.slots[6] = '{KIND_TX, 24'hC3, 1'b0};
            scr.slots[7] = '{KIND_TX, 24'h00, 1'b1};
            scr.count = 4'd8;
            phase_d = PH_POLL_DONE;
          end else begin
            scr.slots[1] = '{KIND_TX, 24'h02, 1'b0};
            scr.slots[2] = '{KIND_TX, {20'd0, col_q[11:8]}, 1'b0};
            scr.slots[3] = '{KIND_TX, {16'd0, col_q[7:0]}, 1'b0};
            scr.count = 4'd4;
            phase_d = PH_PAYLOAD;
          end
        end else begin
          scr.slots[0] = '{KIND_TX, 24'h03, 1'b0};
          scr.slots[1] = '{KIND_TX, {20'd0, col_q[11:8]}, 1'b0};
          scr.slots[2] = '{KIND_TX, {16'd0, col_q[7:0]}, 1'b0};
          if (rem_q == 12'd0) begin
            scr.slots[3] = '{KIND_TX, 24'h00, 1'b1};
            scr.slots[4] = '{KIND_DONE, 24'h0, 1'b0};
            scr.count = 4'd5;
            phase_d = PH_IDLE;
          end else begin
            scr.slots[3] = '{KIND_TX, 24'h00, 1'b0};
            scr.count = 4'd4;
            phase_d = PH_READ_DATA;
          end
        end
      end else if (phase_q == PH_READ_DATA && rem_q != 12'd0) begin
        rem_d = rem_dec;
        scr.slots[0] = '{KIND_RD, {16'd0, item_i.data_byte}, rem_dec == 12'd0};
        if (rem_dec == 12'd0) begin
          scr.slots[1] = '{KIND_DONE, 24'h0, 1'b0};
          scr.count = 4'd2;
          phase_d = PH_IDLE;
        end else begin
          scr.count = 4'd1;
        end
      end else if (phase_q == PH_ID_DATA && rem_q != 12'd0) begin
        id_d  = id_next;
        rem_d = rem_dec;
        if (rem_dec == 12'd0) begin
          scr.slots[0] = '{KIND_ID, id_next, 1'b0};
          scr.slots[1] = '{KIND_DONE, 24'h0, 1'b0};
          scr.count = 4'd2;
          phase_d = PH_IDLE;
        end
      end
    end
    scr.sel = 8'd1 << dev_d;
  end

  // operation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      dev_q   <= '0;
      page_q  <= '0;
      col_q   <= '0;
      rem_q   <= '0;
      id_q    <= '0;
    end else begin
      phase_q <= phase_d;
      dev_q   <= dev_d;
      page_q  <= page_d;
      col_q   <= col_d;
      rem_q   <= rem_d;
      id_q    <= id_d;
    end
  end

  assign script_valid_o = valid_i && (scr.count != 4'd0);
  assign script_o       = scr;

endmodule

>>> hdl/snc_queue.sv
// ----------------------------------------------------------------------------
// snc_queue: script queue between front and back
// Small two-entry queue of result scripts with registered storage.
// ----------------------------------------------------------------------------
module snc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  snc_pkg::snc_script_t wdata_i,
  output logic                 full_o,
  input  logic                 rd_i,
  output logic                 empty_o,
  output snc_pkg::snc_script_t rdata_o
);
  import snc_pkg::*;

  snc_script_t mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr_i} - {1'b0, rd_i};
    end
  end

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rp_q];

endmodule

>>> hdl/snc_back.sv
// ----------------------------------------------------------------------------
// snc_back: result sequencer
// Steps through the slots of the oldest script, one result per transfer.
// ----------------------------------------------------------------------------
module snc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  snc_pkg::snc_script_t script_i,
  output logic                 q_pop_o,
  output logic                 empty_o,
  input  logic                 pop_i,
  output snc_pkg::snc_out_t    result_o
);
  import snc_pkg::*;

  logic [2:0] idx_q;
  snc_slot_t  cur;
  logic       is_last;
  logic       take;

  assign cur     = script_i.slots[idx_q];
  assign is_last = ({1'b0, idx_q} + 4'd1) == script_i.count;
  assign empty_o = q_empty_i;
  assign take    = pop_i && !q_empty_i;
  assign q_pop_o = take && is_last;

  // slot index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (take) begin
      idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  // result fields
  always_comb begin
    result_o.kind          = cur.kind;
    result_o.value         = cur.value;
    result_o.frame_end     = cur.frame_end;
    result_o.device_select = (cur.kind == KIND_DONE) ? 8'd0 : script_i.sel;
    result_o.last          = is_last;
  end

endmodule

>>> hdl/spi_nand_command_sequencer.sv
// ----------------------------------------------------------------------------
// spi_nand_command_sequencer: command frame sequencer for spi nand devices
// Turns operation requests and received bytes into transmit, read and id
// results for a downstream spi shifter.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_i and push; a transfer happens when push is
//   high and full is low. Start requests, payload bytes and received
//   bytes all enter here.
//   Result queue: while empty is low out_o holds the oldest result; pop
//   takes it. Each item makes 0 to 8 results, the last one flagged.
//   Config: cfg_we_i writes cfg_wdata_i into the unprotect status byte.
//   Results: an item's results enter the script queue at its transfer.
//   Throughput: one item per cycle is taken while the two-entry script
//   queue has room; the back end drains one result per cycle while pop
//   is high, and an item has at most 8 results.
//   Reset: idle, device register 0, status byte 0x83, queue empty.
//   When the receiver stalls the script queue fills and full rises.
// ----------------------------------------------------------------------------
module spi_nand_command_sequencer #(
  parameter int unsigned DeviceCount = snc_pkg::DeviceCountDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  snc_pkg::snc_in_t  in_i,
  output logic              empty,
  input  logic              pop,
  output snc_pkg::snc_out_t out_o
);
  import snc_pkg::*;

  logic        s_valid, q_full, q_empty, q_pop;
  snc_script_t s_data, q_data;

  snc_front #(.DeviceCount(DeviceCount)) u_front (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .valid_i(push && !q_full), .item_i(in_i),
    .script_valid_o(s_valid), .script_o(s_data)
  );

  snc_queue u_queue (
    .clk_i, .rst_ni, .wr_i(s_valid), .wdata_i(s_data), .full_o(q_full),
    .rd_i(q_pop), .empty_o(q_empty), .rdata_o(q_data)
  );

  snc_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .script_i(q_data), .q_pop_o(q_pop),
    .empty_o(empty), .pop_i(pop), .result_o(out_o)
  );

  assign full = q_full;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the spi nand command sequencer
// Drives start requests, payload bytes and received bytes through the input
// queue, predicts every result the block should produce and checks each popped
// result against the oldest prediction, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import snc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_POLL_DONE, S_POLL_ERASE, S_POLL_READ, S_PAYLOAD, S_READ_DATA, S_ID_DATA
  } seq_state_e;

  // predicts the command frames and keeps the expected results in order
  class frame_scoreboard;
    seq_state_e  state;
    logic [2:0]  dev;
    logic [15:0] page;
    logic [11:0] column;
    logic [11:0] remaining;
    logic [23:0] id_acc;
    logic [7:0]  protect_byte;
    snc_out_t    expected_q[$];
    snc_out_t    item_q[$];
    int          errors;
    int          checked;

    function new();
      state = S_IDLE;
      dev = '0;
      page = '0;
      column = '0;
      remaining = '0;
      id_acc = '0;
      protect_byte = 8'h83;
      errors = 0;
      checked = 0;
    endfunction

    function void report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void emit(logic [1:0] k, logic [23:0] v, logic fe, logic [7:0] sel);
      snc_out_t r;
      r.kind = k;
      r.value = v;
      r.frame_end = fe;
      r.device_select = sel;
      r.last = 1'b0;
      item_q.push_back(r);
    endfunction

    function void tx(logic [7:0] b, logic fe);
      emit(KIND_TX, {16'h0, b}, fe, 8'(1 << dev));
    endfunction

    function void done();
      state = S_IDLE;
      emit(KIND_DONE, '0, 1'b0, '0);
    endfunction

    function void status_poll();
      tx(8'h0F, 0);
      tx(8'hC3, 0);
      tx(8'h00, 1);
    endfunction

    function void page_cmd(logic [7:0] opc, logic [7:0] second);
      tx(opc, 0);
      tx(second, 0);
      tx(page[15:8], 0);
      tx(page[7:0], 1);
    endfunction

    function void program_start();
      tx(8'h06, 1);
      if (remaining == 0) begin
        page_cmd(8'h10, 8'h00);
        status_poll();
        state = S_POLL_DONE;
      end else begin
        tx(8'h02, 0);
        tx({4'h0, column[11:8]}, 0);
        tx(column[7:0], 0);
        state = S_PAYLOAD;
      end
    endfunction

    function void read_start();
      tx(8'h03, 0);
      tx({4'h0, column[11:8]}, 0);
      tx(column[7:0], 0);
      tx(8'h00, remaining == 0);
      if (remaining == 0) done();
      else state = S_READ_DATA;
    endfunction

    // note an accepted input and queue what it causes
    function void note_item(snc_in_t it);
      item_q.delete();
      if (it.operation <= OP_UNPROT) begin
        if (state == S_IDLE) begin
          dev = it.device;
          page = it.page_address;
          column = it.column_address;
          remaining = (it.operation inside {OP_PROGRAM, OP_ERPROG, OP_READ}) ?
                      it.length : 12'd0;
          case (it.operation)
            OP_ERASE, OP_ERPROG: begin
              tx(8'h06, 1);
              page_cmd(8'hD8, 8'hC3);
              status_poll();
              state = (it.operation == OP_ERASE) ? S_POLL_DONE : S_POLL_ERASE;
            end
            OP_PROGRAM: program_start();
            OP_READ: begin
              page_cmd(8'h13, 8'h00);
              status_poll();
              state = S_POLL_READ;
            end
            OP_ID: begin
              tx(8'h9F, 0);
              tx(8'h00, 0);
              tx(8'h00, 0);
              tx(8'h00, 0);
              tx(8'h00, 1);
              remaining = 12'd3;
              id_acc = '0;
              state = S_ID_DATA;
            end
            default: begin
              tx(8'h1F, 0);
              tx(8'hA0, 0);
              tx(protect_byte, 1);
              done();
            end
          endcase
        end
      end else if (it.operation == OP_PAYLOAD) begin
        if (state == S_PAYLOAD && remaining != 0) begin
          remaining--;
          tx(it.data_byte, remaining == 0);
          if (remaining == 0) begin
            page_cmd(8'h10, 8'h00);
            status_poll();
            state = S_POLL_DONE;
          end
        end
      end else if (state inside {S_POLL_DONE, S_POLL_ERASE, S_POLL_READ}) begin
        if (it.data_byte[0]) status_poll();
        else if (state == S_POLL_DONE) done();
        else if (state == S_POLL_ERASE) program_start();
        else read_start();
      end else if (state == S_READ_DATA && remaining != 0) begin
        remaining--;
        emit(KIND_RD, {16'h0, it.data_byte}, remaining == 0, 8'(1 << dev));
        if (remaining == 0) done();
      end else if (state == S_ID_DATA && remaining != 0) begin
        id_acc = {id_acc[15:0], it.data_byte};
        remaining--;
        if (remaining == 0) begin
          emit(KIND_ID, id_acc, 1'b0, 8'(1 << dev));
          done();
        end
      end
      if (item_q.size() != 0) item_q[item_q.size() - 1].last = 1'b1;
      foreach (item_q[i]) expected_q.push_back(item_q[i]);
    endfunction

    // compare one popped result with the oldest prediction
    function void check_result(snc_out_t got);
      snc_out_t exp_r;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.kind != exp_r.kind)
        report($sformatf("kind %0d, want %0d", got.kind, exp_r.kind));
      if (got.value != exp_r.value)
        report($sformatf("value %h, want %h", got.value, exp_r.value));
      if (got.frame_end != exp_r.frame_end)
        report($sformatf("frame_end %b, want %b", got.frame_end, exp_r.frame_end));
      if (got.device_select != exp_r.device_select)
        report($sformatf("device_select %h, want %h", got.device_select,
                         exp_r.device_select));
      if (got.last != exp_r.last)
        report($sformatf("last %b, want %b", got.last, exp_r.last));
    endfunction
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;
  logic     push = 1'b0;
  logic     full;
  snc_in_t  in_item = '0;
  logic     empty;
  logic     pop = 1'b0;
  snc_out_t out_res;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  int items_sent = 0;
  frame_scoreboard sb = new();

  spi_nand_command_sequencer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .push       (push),
    .full       (full),
    .in_i       (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_o      (out_res)
  );

  always #2 clk_i = ~clk_i;

  // result side: check each transfer, then decide on the next pop
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) sb.check_result(out_res);
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin
    #2ms;
    $display("timeout with %0d results pending", sb.expected_q.size());
    $display("[spi_nand_command_sequencer] ERROR");
    $finish;
  end

  // offer one item and wait for its transfer
  task automatic send(snc_in_t it);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_op(logic [2:0] op, logic [2:0] d, logic [15:0] pg,
                         logic [11:0] col, logic [11:0] len, logic [7:0] b);
    snc_in_t it;
    it.operation = op;
    it.device = d;
    it.page_address = pg;
    it.column_address = col;
    it.length = len;
    it.data_byte = b;
    send(it);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_protect(logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.protect_byte = v;
  endtask

  // mostly items that move the current operation on, some noise
  function automatic snc_in_t pick_item();
    snc_in_t it;
    it = snc_in_t'(54'({$urandom, $urandom}));
    if ($urandom_range(9) == 0) return it;
    case (sb.state)
      S_IDLE: begin
        it.operation = 3'($urandom_range(5));
        it.length = ($urandom_range(7) == 0) ? 12'd0 : 12'($urandom_range(6));
      end
      S_PAYLOAD: it.operation = OP_PAYLOAD;
      S_POLL_DONE, S_POLL_ERASE, S_POLL_READ: begin
        it.operation = OP_RXBYTE;
        it.data_byte[0] = ($urandom_range(99) < 30);
      end
      default: it.operation = OP_RXBYTE;
    endcase
    return it;
  endfunction

  task automatic random_items(int count);
    repeat (count) send(pick_item());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: every operation, field extremes and ignored items
    send_op(OP_UNPROT, 3'd0, 16'h0000, 12'h000, 12'h000, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'hFF);
    send_op(OP_PAYLOAD, 3'd1, 16'h0, 12'h0, 12'h0, 8'h55);
    send_op(OP_ERASE, 3'd7, 16'hFFFF, 12'hFFF, 12'hFFF, 8'h00);
    send_op(OP_READ, 3'd2, 16'h1234, 12'h0, 12'h1, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h01);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'hFE);
    send_op(OP_PROGRAM, 3'd3, 16'h0000, 12'hFFF, 12'h000, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_PROGRAM, 3'd4, 16'hA5A5, 12'h5A5, 12'h002, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_PAYLOAD, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_PAYLOAD, 3'd0, 16'h0, 12'h0, 12'h0, 8'hFF);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_ERPROG, 3'd5, 16'h00FF, 12'h0F0, 12'h001, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_PAYLOAD, 3'd0, 16'h0, 12'h0, 12'h0, 8'h3C);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_READ, 3'd6, 16'hFF00, 12'h800, 12'h000, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_ID, 3'd1, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_ERASE, 3'd2, 16'h1111, 12'h0, 12'h0, 8'h00);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'hEF);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'hAA);
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h21);

    // random traffic under the three stall patterns and several status bytes
    write_protect(8'h00);
    send_idle = 32;
    recv_idle = 64;
    random_items(40);
    write_protect(8'hFF);
    send_idle = 64;
    recv_idle = 32;
    random_items(40);
    write_protect(8'($urandom));
    send_idle = 0;
    recv_idle = 0;
    random_items(20);

    // receiver holds off while items keep coming, so the input backs up
    hold_cycles = 300;
    random_items(20);

    // one longer program load
    drain();
    while (sb.state != S_IDLE)
      send_op((sb.state == S_PAYLOAD) ? OP_PAYLOAD : OP_RXBYTE, 3'd0, 16'h0, 12'h0,
              12'h0, 8'h00);
    send_op(OP_PROGRAM, 3'($urandom), 16'($urandom), 12'($urandom), 12'h010, 8'h00);
    while (sb.state == S_PAYLOAD)
      send_op(OP_PAYLOAD, 3'd0, 16'h0, 12'h0, 12'h0, 8'($urandom));
    send_op(OP_RXBYTE, 3'd0, 16'h0, 12'h0, 12'h0, 8'h00);
    send_op(OP_UNPROT, 3'($urandom), 16'h0, 12'h0, 12'h0, 8'h00);

    drain();
    $display("covered %0d items and %0d results over all six operations,", items_sent,
             sb.checked);
    $display("three stall patterns, a long receiver hold and a longer program load");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[spi_nand_command_sequencer] OK");
    end else begin
      $display("%0d mismatches, %0d results never seen", sb.errors, sb.expected_q.size());
      $display("[spi_nand_command_sequencer] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/snc_pkg.sv
hdl/snc_front.sv
hdl/snc_queue.sv
hdl/snc_back.sv
hdl/spi_nand_command_sequencer.sv
verif/tb.sv
